>>> src/tlf_pkg.sv
// Package for the text line folder: character codes, widths and the job record
// that the front part hands to the back part. It depends on nothing else.
package tlf_pkg;

  localparam int WORD_DEPTH_DEF = 64;
  localparam int TAB_STOP_DEF   = 8;
  localparam int WORD_DEPTH_MAX = 64;
  localparam int CNT_W          = $clog2(WORD_DEPTH_MAX);
  localparam int COL_W          = 7;
  localparam int ADV_W          = 5;

  localparam logic [5:0] FOLD_RESET = 6'd56;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // One job lists, in emission order, what a single item causes.
  typedef struct packed {
    logic             nl;
    logic             sp;
    logic [CNT_W-1:0] cnt;
    logic             tail_en;
    logic [7:0]       tail;
    logic             sp2;
  } job_t;

endpackage

>>> src/tlf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.
module tlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tlf_job_queue.sv
// Two-entry queue of jobs between the front and the back part.
// Depends on tlf_pkg.
module tlf_job_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tlf_pkg::job_t job_in,
  output logic         full,
  input  logic         pop,
  output tlf_pkg::job_t job_out,
  output logic         empty
);

  import tlf_pkg::*;

  job_t       entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = entry[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> src/tlf_front.sv
// Front part: takes characters, tracks column and held word, writes the word
// store and turns each item into at most one job. Depends on tlf_pkg.
module tlf_front #(
  parameter int WORD_DEPTH = tlf_pkg::WORD_DEPTH_DEF,
  parameter int TAB_STOP   = tlf_pkg::TAB_STOP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    char_code,
  input  logic                          end_of_text,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [5:0]                    cfg_data,
  output logic                          job_push,
  output tlf_pkg::job_t                 job,
  input  logic                          job_full,
  input  logic                          dump_done,
  output logic                          ram_we,
  output logic [$clog2(WORD_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                    ram_wdata
);

  import tlf_pkg::*;

  localparam int AW         = $clog2(WORD_DEPTH);
  localparam int HOLD_LIMIT = WORD_DEPTH - 2;
  localparam int COLS       = 2 ** COL_W;

  // Tab advance for every column value, built at elaboration by counting.
  function automatic logic [COLS*ADV_W-1:0] tab_table(input int ts);
    logic [COLS*ADV_W-1:0] t;
    int r;
    t = '0;
    r = 0;
    for (int i = 0; i < COLS; i++) begin
      t[i*ADV_W +: ADV_W] = ADV_W'(ts - r);
      r = (r == ts - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam logic [COLS*ADV_W-1:0] TAB_ADV = tab_table(TAB_STOP);

  function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] a,
                                               input logic [ADV_W-1:0] b);
    logic [COL_W:0] s;
    s = {1'b0, a} + {{(COL_W + 1 - ADV_W){1'b0}}, b};
    return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
  endfunction

  logic [5:0]       fold_width;
  logic [COL_W-1:0] column;
  logic             space_held;
  logic [AW-1:0]    word_count;
  logic [COL_W-1:0] columns_since_space;
  logic             dump_busy;

  logic [COL_W-1:0] column_next;
  logic             space_held_next;
  logic [AW-1:0]    word_count_next;
  logic [COL_W-1:0] columns_since_space_next;
  logic             accept;
  logic             store;
  logic [ADV_W-1:0] width;
  logic             job_any;
  job_t             j;

  assign cfg_ready = 1'b1;
  assign full      = job_full || dump_busy;
  assign accept    = push && !full;

  always_comb begin
    column_next              = column;
    space_held_next          = space_held;
    word_count_next          = word_count;
    columns_since_space_next = columns_since_space;
    store                    = 1'b0;
    width                    = ADV_W'(1);
    j                        = '0;

    if ({1'b0, column} >= {{(COL_W - 6 + 1){1'b0}}, fold_width}) begin
      j.nl = 1'b1;
      if (space_held_next) begin
        j.cnt                    = CNT_W'(word_count_next);
        column_next              = columns_since_space_next;
        space_held_next          = 1'b0;
        word_count_next          = '0;
        columns_since_space_next = '0;
      end else begin
        column_next = '0;
      end
    end

    if (char_code == CHAR_SPACE || char_code == CHAR_NL) begin
      if (space_held_next) begin
        j.sp  = 1'b1;
        j.cnt = CNT_W'(word_count_next);
      end
      word_count_next          = '0;
      columns_since_space_next = '0;
      if (char_code == CHAR_SPACE) begin
        space_held_next = 1'b1;
        column_next     = sat_add(column_next, ADV_W'(1));
      end else begin
        space_held_next = 1'b0;
        j.tail_en       = 1'b1;
        j.tail          = CHAR_NL;
        column_next     = '0;
      end
    end else begin
      if (char_code == CHAR_TAB) begin
        width = TAB_ADV[column_next*ADV_W +: ADV_W];
      end
      if (space_held_next && word_count_next < AW'(HOLD_LIMIT)) begin
        store                    = 1'b1;
        word_count_next          = word_count_next + AW'(1);
        columns_since_space_next = sat_add(columns_since_space_next, width);
      end else begin
        if (space_held_next) begin
          j.sp  = 1'b1;
          j.cnt = CNT_W'(word_count_next);
        end
        space_held_next          = 1'b0;
        word_count_next          = '0;
        columns_since_space_next = '0;
        j.tail_en                = 1'b1;
        j.tail                   = char_code;
      end
      column_next = sat_add(column_next, width);
    end

    // The end flag releases the hold; a freshly stored byte shares the
    // space and dump slots, a freshly held space goes out last.
    if (end_of_text) begin
      if (space_held_next) begin
        if (store) begin
          j.sp  = 1'b1;
          j.cnt = CNT_W'(word_count_next);
        end else begin
          j.sp2 = 1'b1;
        end
      end
      space_held_next          = 1'b0;
      word_count_next          = '0;
      columns_since_space_next = '0;
    end
  end

  assign job_any   = j.nl || j.sp || (j.cnt != '0) || j.tail_en || j.sp2;
  assign job_push  = accept && job_any;
  assign job       = j;
  assign ram_we    = accept && store;
  assign ram_waddr = word_count;
  assign ram_wdata = char_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_width          <= FOLD_RESET;
      column              <= '0;
      space_held          <= 1'b0;
      word_count          <= '0;
      columns_since_space <= '0;
      dump_busy           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fold_width <= cfg_data;
      end
      if (accept) begin
        column              <= column_next;
        space_held          <= space_held_next;
        word_count          <= word_count_next;
        columns_since_space <= columns_since_space_next;
      end
      // The store must not be rewritten until the back part has read it out.
      if (job_push && j.cnt != '0) begin
        dump_busy <= 1'b1;
      end else if (dump_done) begin
        dump_busy <= 1'b0;
      end
    end
  end

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> word_count < AW'(HOLD_LIMIT))
    else $error("word store written beyond the hold limit");

  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    dump_done |-> dump_busy)
    else $error("word dump finished with none outstanding");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    (job_push && j.cnt != '0) |=> (dump_busy && !push) || full)
    else $error("input not held off while a word dump is outstanding");

endmodule

>>> src/tlf_back.sv
// Back part: carries out jobs one result per cycle while the result queue has
// room, reads held words from the store, queues output. Depends on tlf_pkg.
module tlf_back #(
  parameter int WORD_DEPTH = tlf_pkg::WORD_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlf_pkg::job_t                 job,
  input  logic                          job_empty,
  output logic                          job_pop,
  output logic                          dump_done,
  output logic [$clog2(WORD_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_char,
  output logic                          last_of_run
);

  import tlf_pkg::*;

  localparam int AW     = $clog2(WORD_DEPTH);
  localparam int ODEPTH = 4;
  localparam int OPW    = $clog2(ODEPTH);

  job_t             cur;
  logic             cur_valid;
  logic [CNT_W-1:0] idx;

  job_t             cur_next;
  logic [CNT_W-1:0] idx_next;
  logic             tok_ram;
  logic [7:0]       tok_lit;
  logic             rest;
  logic             room;
  logic             issue;
  logic             done;
  logic             load;

  logic             s1_valid;
  logic             s1_ram;
  logic [7:0]       s1_lit;
  logic             s1_last;

  logic [8:0]       ofifo [ODEPTH];
  logic [OPW-1:0]   ohead;
  logic [OPW-1:0]   otail;
  logic [OPW:0]     ocount;
  logic             opop;

  // Pick the first outstanding result of the current job.
  always_comb begin
    cur_next = cur;
    idx_next = idx;
    tok_ram  = 1'b0;
    tok_lit  = CHAR_SPACE;
    if (cur.nl) begin
      tok_lit     = CHAR_NL;
      cur_next.nl = 1'b0;
    end else if (cur.sp) begin
      cur_next.sp = 1'b0;
    end else if (idx != cur.cnt) begin
      tok_ram  = 1'b1;
      idx_next = idx + CNT_W'(1);
    end else if (cur.tail_en) begin
      tok_lit          = cur.tail;
      cur_next.tail_en = 1'b0;
    end else begin
      cur_next.sp2 = 1'b0;
    end
  end

  assign rest = cur_next.nl || cur_next.sp || (idx_next != cur.cnt) ||
                cur_next.tail_en || cur_next.sp2;
  assign room      = ({1'b0, ocount} + {{(OPW + 1){1'b0}}, s1_valid}) < (OPW + 2)'(ODEPTH);
  assign issue     = cur_valid && room;
  assign done      = issue && !rest;
  assign load      = !job_empty && (!cur_valid || done);
  assign job_pop   = load;
  assign dump_done = issue && tok_ram && (idx_next == cur.cnt);
  assign ram_raddr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
      idx <= '0;
    end else if (issue) begin
      cur <= cur_next;
      idx <= idx_next;
    end
    s1_ram  <= tok_ram;
    s1_lit  <= tok_lit;
    s1_last <= !rest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (load) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Result queue: the store data arrive in the cycle after the read is issued.
  assign opop        = pop && !empty;
  assign empty       = (ocount == '0);
  assign out_char    = ofifo[ohead][8:1];
  assign last_of_run = ofifo[ohead][0];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      ofifo[otail] <= {(s1_ram ? ram_rdata : s1_lit), s1_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= '0;
      otail  <= '0;
      ocount <= '0;
    end else begin
      if (s1_valid) otail <= otail + OPW'(1);
      if (opop)     ohead <= ohead + OPW'(1);
      if (s1_valid && !opop) begin
        ocount <= ocount + (OPW + 1)'(1);
      end else if (opop && !s1_valid) begin
        ocount <= ocount - (OPW + 1)'(1);
      end
    end
  end

  a_result_fits: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ocount < (OPW + 1)'(ODEPTH))
    else $error("result queue overrun");

  a_job_has_work: assert property (@(posedge clk) disable iff (rst)
    load |=> cur_valid)
    else $error("loaded job not held");

endmodule

>>> src/text_line_folder.sv
// Top level of the text line folder: front part, job queue, back part and
// the word store. Depends on tlf_pkg, tlf_front, tlf_job_queue, tlf_back, tlf_ram.
//
//  channel   handshake           payload
//  input     push / full         char_code, end_of_text
//  result    empty / pop         out_char, last_of_run
//  config    cfg_valid/cfg_ready cfg_data (fold_width)
//
// An item is taken while the job queue has room and no word dump is still
// being read from the store. The back part gives one result per cycle while
// its result queue has room; each result passes the s1 registers on its way
// into the output queue. An item may give no result at all.
// Reset is synchronous and needs no clearing pass; the output side stalls
// the back part through its four-entry result queue; the stall reaches the input.
module text_line_folder #(
  parameter int WORD_DEPTH = tlf_pkg::WORD_DEPTH_DEF,
  parameter int TAB_STOP   = tlf_pkg::TAB_STOP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  import tlf_pkg::*;

  localparam int AW = $clog2(WORD_DEPTH);

  logic          job_push;
  job_t          job_in;
  logic          job_full;
  logic          job_pop;
  job_t          job_out;
  logic          job_empty;
  logic          dump_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  tlf_front #(
    .WORD_DEPTH (WORD_DEPTH),
    .TAB_STOP   (TAB_STOP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .job_push    (job_push),
    .job         (job_in),
    .job_full    (job_full),
    .dump_done   (dump_done),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  tlf_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (job_full),
    .pop     (job_pop),
    .job_out (job_out),
    .empty   (job_empty)
  );

  tlf_ram #(
    .WIDTH (8),
    .DEPTH (WORD_DEPTH)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlf_back #(
    .WORD_DEPTH (WORD_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (job_out),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .dump_done   (dump_done),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

>>> sim/tlf_checker.sv
// Checker for the text line folder: watches the input, result and config channels,
// predicts the folded text and compares it result by result. Depends on tlf_pkg.
module tlf_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic       last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlf_pkg::*;

  localparam int HOLD_LIMIT = WORD_DEPTH_DEF - 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } folded_char_t;

  folded_char_t folded_q[$];
  folded_char_t want;

  logic [5:0] fold_w;
  logic [6:0] line_col;
  logic       gap_open;
  logic [7:0] held_bytes[WORD_DEPTH_DEF];
  int         held_n;
  logic [6:0] held_cols;

  logic [7:0] burst[64];
  int         burst_n;

  function automatic logic [6:0] col_add(input logic [6:0] a, input logic [4:0] b);
    logic [7:0] s;
    s = {1'b0, a} + {3'b000, b};
    return (s > 8'd127) ? 7'd127 : s[6:0];
  endfunction

  function automatic void emit(input logic [7:0] c);
    if (burst_n < 64) begin
      burst[burst_n] = c;
      burst_n++;
    end
  endfunction

  function automatic void emit_held();
    for (int i = 0; i < held_n; i++) emit(held_bytes[i]);
  endfunction

  // The pending space and the word after it go out unchanged.
  function automatic void release_hold();
    if (gap_open) begin
      emit(CHAR_SPACE);
      emit_held();
    end
    gap_open = 1'b0;
    held_n = 0;
    held_cols = '0;
  endfunction

  task automatic fold_char(input logic [7:0] c, input logic eot);
    logic [4:0] adv;
    burst_n = 0;
    if (line_col >= {1'b0, fold_w}) begin
      emit(CHAR_NL);
      if (gap_open) begin
        // The space turns into the line break; the word starts the new line.
        emit_held();
        line_col = held_cols;
        gap_open = 1'b0;
        held_n = 0;
        held_cols = '0;
      end else begin
        line_col = '0;
      end
    end
    if (c == CHAR_SPACE) begin
      release_hold();
      gap_open = 1'b1;
      line_col = col_add(line_col, 5'd1);
    end else if (c == CHAR_NL) begin
      release_hold();
      emit(CHAR_NL);
      line_col = '0;
    end else begin
      adv = (c == CHAR_TAB) ? 5'(TAB_STOP_DEF - int'(line_col) % TAB_STOP_DEF) : 5'd1;
      if (gap_open && held_n < HOLD_LIMIT) begin
        held_bytes[held_n] = c;
        held_n++;
        held_cols = col_add(held_cols, adv);
      end else begin
        release_hold();
        emit(c);
      end
      line_col = col_add(line_col, adv);
    end
    if (eot) release_hold();
    for (int i = 0; i < burst_n; i++) begin
      folded_q.push_back('{ch: burst[i], last: (i == burst_n - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fold_w = FOLD_RESET;
      line_col = '0;
      gap_open = 1'b0;
      held_n = 0;
      held_cols = '0;
      folded_q.delete();
    end else begin
      if (pop && !empty) begin
        if (folded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: out_char=%h last_of_run=%b",
                     $realtime, out_char, last_of_run);
        end else begin
          want = folded_q.pop_front();
          if (want.ch !== out_char || want.last !== last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected out_char=%h last_of_run=%b, got out_char=%h last_of_run=%b",
                       $realtime, want.ch, want.last, out_char, last_of_run);
          end
        end
      end
      if (cfg_valid && cfg_ready) fold_w = cfg_data;
      if (push && !full) fold_char(char_code, end_of_text);
    end
    outstanding = folded_q.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the text line folder: clock, reset, character stimulus,
// fold width changes and the verdict. Depends on tlf_pkg, tlf_checker and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlf_pkg::*;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] char_code;
  logic       end_of_text;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;

  int mismatches;
  int outstanding;

  // steady turns off idling on both sides; hold_req asks the reader for a long stall.
  bit steady;
  bit hold_req;

  text_line_folder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  tlf_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly words of letters with spaces, some tabs and newlines, some raw bytes.
  function automatic logic [7:0] next_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 72) return CHAR_SPACE;
    if (r < 77) return CHAR_TAB;
    if (r < 82) return CHAR_NL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = pick_gap();
    while (gap > 0) begin
      push <= 1'b0;
      @(negedge clk);
      gap--;
    end
    push <= 1'b1;
    char_code <= c;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_text(input int n);
    repeat (n) send_char(next_char(), $urandom_range(0, 29) == 0);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // Items without results may still be in flight.
    repeat (16) @(negedge clk);
  endtask

  task automatic set_fold(input logic [5:0] w);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    char_code = '0;
    end_of_text = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short directed run with a narrow line.
    set_fold(6'd6);
    send_char("A", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char("b", 1'b0);
    send_char(CHAR_TAB, 1'b0);
    send_char("c", 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char("d", 1'b0);
    send_char(CHAR_NL, 1'b0);
    // A full line followed by a newline gives a break and then the newline.
    for (int i = 0; i < 6; i++) send_char(8'(8'h31 + i), 1'b0);
    send_char(CHAR_NL, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CHAR_SPACE, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);

    set_fold(6'd1);
    send_text(40);
    set_fold(6'd0);
    send_text(30);

    // The widest line holds the longest word the store allows before it breaks.
    set_fold(6'd63);
    send_char(CHAR_NL, 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    repeat (63) send_char(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
    send_char("z", 1'b1);

    set_fold(FOLD_RESET);
    hold_req = 1'b1;
    send_text(80);

    for (int p = 0; p < 3; p++) begin
      set_fold(6'($urandom_range(1, 63)));
      steady = (p == 1);
      send_text(40);
    end
    steady = 1'b0;

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Reader side: random stalls, and one long hold-off so that the block backs up.
  initial begin
    int idle;
    pop = 1'b0;
    idle = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_req) begin
        pop <= 1'b0;
        hold_req = 1'b0;
        repeat (400) @(negedge clk);
      end else if (idle > 0) begin
        pop <= 1'b0;
        idle--;
      end else begin
        pop <= 1'b1;
        idle = pick_gap();
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
